/* rtl/core/maze_backtracker_walker_macros.svh */
// Assertion macros shared by the maze walker RTL.
`ifndef MAZE_BACKTRACKER_WALKER_MACROS_SVH
`define MAZE_BACKTRACKER_WALKER_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define MBW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define MBW_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MBW_ASSERT(lbl, clk, rst_n, prop, msg)
`define MBW_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

/* rtl/core/mbw_pkg.sv */
// Types, constants and helpers for the maze walker.
`timescale 1ns / 1ps

package mbw_pkg;

  localparam int NODES_PER_SIDE = 16;
  localparam int NODE_TOTAL     = NODES_PER_SIDE * NODES_PER_SIDE;
  localparam int GRID_SIDE      = 2 * NODES_PER_SIDE + 1;
  localparam int COORD_W        = $clog2(NODES_PER_SIDE);
  localparam int NODE_W         = $clog2(NODE_TOTAL);
  localparam int CNT_W          = $clog2(NODE_TOTAL + 1);
  localparam int POS_W          = 6;
  localparam int OUT_COORD_W    = 4;
  localparam int STK_W          = 2 * COORD_W;

  // node word: visited bit, one bit towards the right neighbour, one downwards
  localparam int PASS_W     = 3;
  localparam int PASS_VISIT = 2;
  localparam int PASS_RIGHT = 1;
  localparam int PASS_DOWN  = 0;
  localparam logic [PASS_W-1:0] WORD_VISITED = PASS_W'(1 << PASS_VISIT);

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam int         MODE_READ_BIT = 1;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    ST_STARTED     = 3'd0,
    ST_CARVED      = 3'd1,
    ST_RETRY       = 3'd2,
    ST_BACKTRACKED = 3'd3,
    ST_FINISHED    = 3'd4,
    ST_READ_DONE   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CK_WALL  = 2'd0,
    CK_OPEN  = 2'd1,
    CK_START = 2'd2
  } cell_kind_t;

  typedef enum logic [1:0] {
    CC_WALL  = 2'd0,
    CC_NODE  = 2'd1,
    CC_RIGHT = 2'd2,
    CC_DOWN  = 2'd3
  } cell_class_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [1:0]       direction;
  } in_t;

  typedef struct packed {
    status_t                status;
    logic [OUT_COORD_W-1:0] node_col;
    logic [OUT_COORD_W-1:0] node_row;
    cell_kind_t             cell_kind;
    logic                   all_visited;
  } out_t;

  typedef struct packed {
    logic               inb;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [NODE_W-1:0]  idx;
  } nbr_t;

  typedef struct packed {
    cell_class_t       cls;
    logic [NODE_W-1:0] idx;
  } cell_req_t;

  function automatic logic [NODE_W-1:0] node_idx(input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] col);
    node_idx = NODE_W'(int'(row) * NODES_PER_SIDE + int'(col));
  endfunction

endpackage

/* rtl/core/maze_backtracker_walker.sv */
// Top level of the randomised depth-first maze walker.
`timescale 1ns / 1ps
`include "maze_backtracker_walker_macros.svh"

// Maze walker: builds a maze on a 16 x 16 node lattice (grid of 33 x 33 cells)
// by randomised depth-first search, one request at a time, driven by an
// external 2-bit direction draw. Mode 0 starts a walk (clears the maze, start
// column/row saturate to the lattice), mode 1 takes one step (carve, retry,
// backtrack or finished), modes 2 and 3 read one grid cell. Each request gives
// exactly one result; the node position and all-visited flag in it reflect
// the state after that request. A step uses the single neighbour unit, which
// visits the four directions one per cycle, with each word from the node word
// RAM's registered read arriving in the cycle after its lookup; a carve then
// writes the new node's word, plus a read-modify-write of the current node's
// word when the passage lies there (down or right), and a backtrack waits on
// the return stack RAM's read. While one request is in flight in_ready is low;
// a finished result sits in the output register, so the next request can be
// accepted before it is taken, and a result that finds the register still
// full waits until it is. Each node word (visited, right and down passage
// bits) lives in RAM; one word-valid flip-flop per node makes unwritten words
// read as zero, so a start clears the maze at once and no clearing pass is
// needed after reset.
module maze_backtracker_walker
  import mbw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_SCAN     = 10'b0000000010,
    S_DECIDE   = 10'b0000000100,
    S_CARVE_RD = 10'b0000001000,
    S_CARVE_WR = 10'b0000010000,
    S_POP_RD   = 10'b0000100000,
    S_POP_WR   = 10'b0001000000,
    S_READ_RD  = 10'b0010000000,
    S_READ_WR  = 10'b0100000000,
    S_EMIT     = 10'b1000000000
  } state_t;

  // ---- control state ----
  state_t              state_r,   state_nxt;
  logic [COORD_W-1:0]  cur_col_r, cur_col_nxt;
  logic [COORD_W-1:0]  cur_row_r, cur_row_nxt;
  logic [NODE_W-1:0]   start_r,   start_nxt;
  logic [CNT_W-1:0]    count_r,   count_nxt;
  logic [CNT_W-1:0]    depth_r,   depth_nxt;
  logic [NODE_TOTAL-1:0] pv_r,      pv_nxt;      // node word holds data
  logic                out_valid_r, out_valid_nxt;

  // ---- per-request payload ----
  dir_t                dir_r,    dir_nxt;
  dir_t                scan_k_r, scan_k_nxt;
  logic                q_inb_r,  q_inb_nxt;      // looked-up neighbour in bounds
  logic                q_pv_r,   q_pv_nxt;       // its word valid
  logic                any_r,    any_nxt;
  logic                drawn_r,  drawn_nxt;
  logic [PASS_W-1:0]   nword_r,  nword_nxt;      // word of the drawn neighbour
  cell_req_t           cell_r,   cell_nxt;
  status_t             status_r, status_nxt;
  cell_kind_t          kind_r,   kind_nxt;
  out_t                out_r,    out_nxt;

  // ---- shared neighbour unit ----
  dir_t                nbr_dir;
  nbr_t                nb;
  dir_t                prev_dir;
  logic                resp_take;
  logic [PASS_W-1:0]   resp_word;
  logic                resp_open;

  // ---- RAM ports ----
  logic                pass_we;
  logic [NODE_W-1:0]   pass_waddr;
  logic [NODE_W-1:0]   pass_raddr;
  logic [PASS_W-1:0]   pass_wdata;
  logic [PASS_W-1:0]   pass_rdata;
  logic                stk_we;
  logic [STK_W-1:0]    stk_rdata;

  logic [NODE_W-1:0]   cur_idx;
  logic [CNT_W-1:0]    depth_m1;
  cell_req_t           cell_in;
  logic [COORD_W-1:0]  sx;
  logic [COORD_W-1:0]  sy;
  logic [NODE_W-1:0]   start_in;
  logic                emit_go;
  logic [PASS_W-1:0]   cur_word;
  logic [PASS_W-1:0]   rd_word;
  logic [PASS_W-1:0]   carve_bit;
  logic                carve_far;
  logic                carve_fin;

  assign cur_idx  = node_idx(cur_row_r, cur_col_r);
  assign depth_m1 = depth_r - CNT_W'(1);

  // scan walks the four directions; carve re-uses the unit on the draw
  assign nbr_dir = (state_r == S_SCAN) ? scan_k_r : dir_r;

  mbw_nbr u_nbr (
    .col (cur_col_r),
    .row (cur_row_r),
    .dir (nbr_dir),
    .nb  (nb)
  );

  // word arriving now was looked up for the previous scan direction
  assign prev_dir  = dir_t'(scan_k_r - 2'd1);
  assign resp_take = (state_r == S_SCAN && scan_k_r != DIR_UP) || (state_r == S_DECIDE);
  assign resp_word = q_pv_r ? pass_rdata : '0;
  assign resp_open = q_inb_r && !resp_word[PASS_VISIT];

  mbw_cell u_cell (
    .gx  (in_data.pos_x),
    .gy  (in_data.pos_y),
    .req (cell_in)
  );

  assign cur_word = pv_r[cur_idx] ? pass_rdata : '0;
  assign rd_word  = pv_r[cell_r.idx] ? pass_rdata : '0;

  // up/left carves mark the neighbour's word, down/right the current one
  assign carve_far = (dir_r == DIR_DOWN || dir_r == DIR_RIGHT);
  assign carve_fin = (state_r == S_CARVE_RD && !carve_far) || (state_r == S_CARVE_WR);

  always_comb begin
    carve_bit = '0;
    if (dir_r == DIR_UP || dir_r == DIR_DOWN) begin
      carve_bit[PASS_DOWN] = 1'b1;
    end else begin
      carve_bit[PASS_RIGHT] = 1'b1;
    end
  end

  mbw_ram #(.WIDTH(PASS_W), .DEPTH(NODE_TOTAL)) u_pass_ram (
    .clk   (clk),
    .we    (pass_we),
    .waddr (pass_waddr),
    .wdata (pass_wdata),
    .raddr (pass_raddr),
    .rdata (pass_rdata)
  );

  mbw_ram #(.WIDTH(STK_W), .DEPTH(NODE_TOTAL)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (depth_r[NODE_W-1:0]),
    .wdata ({cur_row_r, cur_col_r}),
    .raddr (depth_m1[NODE_W-1:0]),
    .rdata (stk_rdata)
  );

  // start position saturates onto the lattice
  assign sx = (int'(in_data.pos_x) > NODES_PER_SIDE - 1) ?
              COORD_W'(NODES_PER_SIDE - 1) : COORD_W'(in_data.pos_x);
  assign sy = (int'(in_data.pos_y) > NODES_PER_SIDE - 1) ?
              COORD_W'(NODES_PER_SIDE - 1) : COORD_W'(in_data.pos_y);
  assign start_in = node_idx(sy, sx);

  assign emit_go  = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE);

  // ---- sequencer ----
  always_comb begin
    state_nxt   = state_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    start_nxt   = start_r;
    count_nxt   = count_r;
    depth_nxt   = depth_r;
    pv_nxt      = pv_r;
    dir_nxt     = dir_r;
    scan_k_nxt  = scan_k_r;
    q_inb_nxt   = q_inb_r;
    q_pv_nxt    = q_pv_r;
    any_nxt     = any_r;
    drawn_nxt   = drawn_r;
    nword_nxt   = nword_r;
    cell_nxt    = cell_r;
    status_nxt  = status_r;
    kind_nxt    = kind_r;
    out_nxt     = out_r;
    pass_we     = 1'b0;
    pass_waddr  = cur_idx;
    pass_wdata  = '0;
    pass_raddr  = nb.idx;
    stk_we      = 1'b0;

    out_valid_nxt = out_valid_r && !out_ready;

    // fold in the neighbour word looked up last cycle
    if (resp_take) begin
      any_nxt = any_r | resp_open;
      if (prev_dir == dir_r) begin
        drawn_nxt = resp_open;
        nword_nxt = resp_word;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dir_nxt    = dir_t'(in_data.direction);
          cell_nxt   = cell_in;
          kind_nxt   = CK_WALL;
          scan_k_nxt = DIR_UP;
          any_nxt    = 1'b0;
          drawn_nxt  = 1'b0;
          priority if (in_data.mode[MODE_READ_BIT]) begin
            state_nxt = S_READ_RD;
          end else if (in_data.mode == MODE_STEP) begin
            if (count_r >= CNT_W'(NODE_TOTAL)) begin
              status_nxt = ST_FINISHED;
              state_nxt  = S_EMIT;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            // start walk: wipe the maze and mark the start node
            pv_nxt           = '0;
            pv_nxt[start_in] = 1'b1;
            pass_we          = 1'b1;
            pass_waddr       = start_in;
            pass_wdata       = WORD_VISITED;
            start_nxt        = start_in;
            cur_col_nxt      = sx;
            cur_row_nxt      = sy;
            count_nxt        = CNT_W'(1);
            depth_nxt        = '0;
            status_nxt       = ST_STARTED;
            state_nxt        = S_EMIT;
          end
        end
      end

      S_SCAN: begin
        // look up this direction's word; its data lands next cycle
        q_inb_nxt  = nb.inb;
        q_pv_nxt   = pv_r[nb.idx];
        scan_k_nxt = dir_t'(scan_k_r + 2'd1);
        if (scan_k_r == DIR_RIGHT) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        priority if (any_nxt && drawn_nxt) begin
          state_nxt = S_CARVE_RD;
        end else if (any_nxt) begin
          status_nxt = ST_RETRY;
          state_nxt  = S_EMIT;
        end else if (depth_r != '0) begin
          state_nxt = S_POP_RD;
        end else begin
          status_nxt = ST_FINISHED;
          state_nxt  = S_EMIT;
        end
      end

      S_CARVE_RD: begin
        // new node's word, with the passage when it lies on that side
        pass_we            = 1'b1;
        pass_waddr         = nb.idx;
        pass_wdata         = carve_far ? (nword_r | WORD_VISITED) :
                                         (nword_r | WORD_VISITED | carve_bit);
        pv_nxt[nb.idx]     = 1'b1;
        pass_raddr         = cur_idx;
        state_nxt          = carve_far ? S_CARVE_WR : S_EMIT;
      end

      S_CARVE_WR: begin
        pass_we         = 1'b1;
        pass_waddr      = cur_idx;
        pass_wdata      = cur_word | carve_bit;
        pv_nxt[cur_idx] = 1'b1;
        state_nxt       = S_EMIT;
      end

      S_POP_RD: begin
        depth_nxt = depth_m1;
        state_nxt = S_POP_WR;
      end

      S_POP_WR: begin
        cur_col_nxt = stk_rdata[COORD_W-1:0];
        cur_row_nxt = stk_rdata[STK_W-1:COORD_W];
        status_nxt  = ST_BACKTRACKED;
        state_nxt   = S_EMIT;
      end

      S_READ_RD: begin
        pass_raddr = cell_r.idx;
        state_nxt  = S_READ_WR;
      end

      S_READ_WR: begin
        unique case (cell_r.cls)
          CC_NODE: begin
            if (rd_word[PASS_VISIT]) begin
              kind_nxt = (cell_r.idx == start_r) ? CK_START : CK_OPEN;
            end
          end
          CC_RIGHT: kind_nxt = rd_word[PASS_RIGHT] ? CK_OPEN : CK_WALL;
          CC_DOWN:  kind_nxt = rd_word[PASS_DOWN]  ? CK_OPEN : CK_WALL;
          default:  kind_nxt = CK_WALL;
        endcase
        status_nxt = ST_READ_DONE;
        state_nxt  = S_EMIT;
      end

      S_EMIT: begin
        if (emit_go) begin
          out_nxt.status      = status_r;
          out_nxt.node_col    = OUT_COORD_W'(cur_col_r);
          out_nxt.node_row    = OUT_COORD_W'(cur_row_r);
          out_nxt.cell_kind   = kind_r;
          out_nxt.all_visited = (count_r >= CNT_W'(NODE_TOTAL));
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // last cycle of a carve: push, count and move onto the new node
    if (carve_fin) begin
      if (depth_r < CNT_W'(NODE_TOTAL)) begin
        stk_we    = 1'b1;
        depth_nxt = depth_r + CNT_W'(1);
      end
      count_nxt   = count_r + CNT_W'(1);
      cur_col_nxt = nb.col;
      cur_row_nxt = nb.row;
      status_nxt  = ST_CARVED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      start_r     <= '0;
      count_r     <= '0;
      depth_r     <= '0;
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      start_r     <= start_nxt;
      count_r     <= count_nxt;
      depth_r     <= depth_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_r    <= dir_nxt;
    scan_k_r <= scan_k_nxt;
    q_inb_r  <= q_inb_nxt;
    q_pv_r   <= q_pv_nxt;
    any_r    <= any_nxt;
    drawn_r  <= drawn_nxt;
    nword_r  <= nword_nxt;
    cell_r   <= cell_nxt;
    status_r <= status_nxt;
    kind_r   <= kind_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---- assertions ----
  // every stack entry was pushed by a carve that also counted a node
  `MBW_ASSERT(a_depth_le_count, clk, rst_n, depth_r <= count_r, "stack deeper than visited count")
  `MBW_NEVER(a_count_range, clk, rst_n, count_r > CNT_W'(NODE_TOTAL), "visited count overran")
  `MBW_ASSERT(a_carve_counts, clk, rst_n, carve_fin |=> count_r == $past(count_r) + CNT_W'(1), "carve did not count node")
  `MBW_ASSERT(a_out_hold, clk, rst_n, out_valid_r && !out_ready |=> out_valid_r && $stable(out_r), "waiting result dropped or changed")

endmodule

/* rtl/core/mbw_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/mbw_nbr.sv */
// Neighbour unit: lattice neighbour of a node in one direction, with bound check.
`timescale 1ns / 1ps

module mbw_nbr
  import mbw_pkg::*;
(
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  input  dir_t               dir,
  output nbr_t               nb
);

  localparam logic [COORD_W-1:0] LAST = COORD_W'(NODES_PER_SIDE - 1);

  logic [COORD_W-1:0] ncol;
  logic [COORD_W-1:0] nrow;
  logic               inb;

  always_comb begin
    ncol = col;
    nrow = row;
    inb  = 1'b0;
    unique case (dir)
      DIR_UP: begin
        inb  = (row != '0);
        nrow = row - COORD_W'(1);
      end
      DIR_DOWN: begin
        inb  = (row < LAST);
        nrow = row + COORD_W'(1);
      end
      DIR_LEFT: begin
        inb  = (col != '0);
        ncol = col - COORD_W'(1);
      end
      DIR_RIGHT: begin
        inb  = (col < LAST);
        ncol = col + COORD_W'(1);
      end
      default: inb = 1'b0;
    endcase
  end

  assign nb.inb = inb;
  assign nb.col = ncol;
  assign nb.row = nrow;
  assign nb.idx = node_idx(nrow, ncol);

endmodule

/* rtl/core/mbw_cell.sv */
// Grid cell decode: classifies a grid position and finds the node it maps to.
`timescale 1ns / 1ps

module mbw_cell
  import mbw_pkg::*;
(
  input  logic [POS_W-1:0] gx,
  input  logic [POS_W-1:0] gy,
  output cell_req_t        req
);

  logic [POS_W-1:0]   gx_m1;
  logic [POS_W-1:0]   gy_m1;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  cell_class_t        cls;

  assign gx_m1 = gx - POS_W'(1);
  assign gy_m1 = gy - POS_W'(1);
  assign cx    = COORD_W'(gx_m1[POS_W-1:1]);
  assign cy    = COORD_W'(gy_m1[POS_W-1:1]);

  always_comb begin
    priority if (int'(gx) >= GRID_SIDE || int'(gy) >= GRID_SIDE ||
                 gx == '0 || gy == '0) begin
      cls = CC_WALL;
    end else if (gx[0] && gy[0]) begin
      cls = CC_NODE;
    end else if (gy[0]) begin
      cls = (int'(cx) < NODES_PER_SIDE - 1) ? CC_RIGHT : CC_WALL;
    end else if (gx[0]) begin
      cls = (int'(cy) < NODES_PER_SIDE - 1) ? CC_DOWN : CC_WALL;
    end else begin
      cls = CC_WALL; // wall corner between four nodes
    end
  end

  assign req.cls = cls;
  assign req.idx = node_idx(cy, cx);

endmodule
